// ----- src/group_bitmap_allocator_defines.svh -----
// assertion macros used by the checker file
`ifndef GROUP_BITMAP_ALLOCATOR_DEFINES_SVH
`define GROUP_BITMAP_ALLOCATOR_DEFINES_SVH
// property that must hold when enabled, reported under the given label
`define GBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent holds in the cycle after the condition
`define GBA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ----- src/gba_pkg.sv -----
// package for the group bitmap allocator: sizes, status codes, register indices and request codes
package gba_pkg;
   localparam int MapBitsDefault   = 8192;
   localparam int WordWidthDefault = 64;
   localparam int CfgWidth         = 14;
   localparam int NumWidth         = 32;
   localparam int GroupWidth       = 16;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE    = 2'd1;
   localparam logic [1:0] STATUS_ALREADY_FREE = 2'd2;

   localparam logic [1:0] REG_GROUP_INDEX = 2'd0;
   localparam logic [1:0] REG_INODES      = 2'd1;
   localparam logic [1:0] REG_BLOCKS      = 2'd2;
   localparam logic [1:0] REG_SCAN_BITS   = 2'd3;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;
   localparam logic POOL_INODE   = 1'b0;
   localparam logic POOL_BLOCK   = 1'b1;
endpackage

// ----- src/group_bitmap_allocator.sv -----
// Group bitmap allocator: first-fit allocate and free over an inode bitmap and a block
// bitmap held in one word-wide memory. One request is handled at a time. After reset a
// clearing pass writes every word to zero while no request is taken. An allocate reads
// one word from the memory's read port and checks it on the next cycle, word by word up
// to the first word with a clear bit. A free first reduces the number by a bit-serial
// modulo, then reads, modifies and writes one word. The result sits in an output
// register until taken, and the next request may run meanwhile; it finishes and then waits
// until that register is free.
module group_bitmap_allocator
   import gba_pkg::*;
#(
   parameter int MAP_BITS   = MapBitsDefault,
   parameter int WORD_WIDTH = WordWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item_number[31:0]
   input  logic [1:0]  req_tuser,   // action[0], pool[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], allocated_number[33:2], used_count[47:34]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int MapWords = (MAP_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
   localparam int WAw      = (MapWords > 1) ? $clog2(MapWords) : 1;
   localparam int BAw      = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
   localparam int Depth    = 2 * MapWords;
   localparam int AAw      = WAw + 1;
   localparam int BitW     = WAw + BAw;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MOD, S_FREE_RD, S_FREE_CHK,
      S_MUL, S_DONE, S_OUT
   } state_type;

   logic [WORD_WIDTH-1:0] mem [Depth];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  we;
   logic [AAw-1:0]        waddr, raddr;
   logic [WORD_WIDTH-1:0] wdata;

   state_type state_ff;
   logic [AAw-1:0]        clr_ff;
   logic                  pool_ff;
   logic [31:0]           num_ff;
   logic [31:0]           rem_ff;
   logic [5:0]            cnt_ff;
   logic [WAw:0]          widx_ff;
   logic [31:0]           bit_ff;
   logic [CfgWidth-1:0]   iused_ff, bused_ff;
   logic [GroupWidth-1:0] group_ff;
   logic [CfgWidth-1:0]   inodes_ff, blocks_ff, scan_ff;
   logic [1:0]            status_ff;
   logic [31:0]           number_ff;
   logic [31:0]           prod_ff;
   logic                  rvalid_ff;
   logic [47:0]           rsp_data_ff;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
   end

   logic [CfgWidth-1:0]  per_group;
   logic [WORD_WIDTH-1:0] avail;
   logic [BAw-1:0]       first;
   logic                 found;
   logic [32:0]          rem_sh;
   logic [WORD_WIDTH-1:0] bitmask;
   logic                 in_map;
   logic [BitW-1:0]      found_bit;

   assign per_group = pool_ff ? blocks_ff : inodes_ff;
   assign avail     = ~rd_data_ff;

   always_comb begin
      first = '0;
      found = 1'b0;
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
         if (avail[i]) begin
            first = BAw'(i);
            found = 1'b1;
         end
      end
   end

   assign found_bit = {widx_ff[WAw-1:0], first};
   assign rem_sh    = {rem_ff, num_ff[31]};
   assign in_map    = (bit_ff < 32'(MAP_BITS));
   assign bitmask   = WORD_WIDTH'(1) << bit_ff[BAw-1:0];

   always_comb begin
      we    = 1'b0;
      waddr = clr_ff;
      wdata = '0;
      raddr = {pool_ff, widx_ff[WAw-1:0]};
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
         end
         S_SCAN_CHK: begin
            waddr = {pool_ff, widx_ff[WAw-1:0]};
            wdata = rd_data_ff | (WORD_WIDTH'(1) << first);
            we    = found && (33'(found_bit) < 33'(scan_ff)) && (33'(found_bit) < 33'(MAP_BITS));
         end
         S_FREE_RD: begin
            // the remainder is final here, bit_ff takes it at this edge
            raddr = {pool_ff, rem_ff[BitW-1:BAw]};
         end
         S_FREE_CHK: begin
            waddr = {pool_ff, bit_ff[BitW-1:BAw]};
            wdata = rd_data_ff & ~bitmask;
            we    = in_map && ((rd_data_ff & bitmask) != '0);
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         iused_ff  <= '0;
         bused_ff  <= '0;
         group_ff  <= '0;
         inodes_ff <= CfgWidth'(8192);
         blocks_ff <= CfgWidth'(8192);
         scan_ff   <= CfgWidth'(8192);
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_GROUP_INDEX: group_ff  <= csr_data[GroupWidth-1:0];
               REG_INODES:      inodes_ff <= csr_data[CfgWidth-1:0];
               REG_BLOCKS:      blocks_ff <= csr_data[CfgWidth-1:0];
               REG_SCAN_BITS:   scan_ff   <= csr_data[CfgWidth-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AAw'(1);
               if (clr_ff == AAw'(Depth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  pool_ff   <= req_tuser[1];
                  num_ff    <= (req_tuser[1] == POOL_BLOCK) ? req_tdata : req_tdata - 32'd1;
                  widx_ff   <= '0;
                  rem_ff    <= '0;
                  cnt_ff    <= '0;
                  status_ff <= STATUS_OK;
                  number_ff <= '0;
                  state_ff  <= (req_tuser[0] == ACTION_FREE) ? S_MOD : S_SCAN_RD;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (found) begin
                  if ((33'(found_bit) < 33'(scan_ff)) && (33'(found_bit) < 33'(MAP_BITS))) begin
                     bit_ff <= 32'(found_bit);
                     if (pool_ff) bused_ff <= bused_ff + CfgWidth'(1);
                     else         iused_ff <= iused_ff + CfgWidth'(1);
                     state_ff <= S_MUL;
                  end else begin
                     status_ff <= STATUS_NO_SPACE;
                     state_ff  <= S_OUT;
                  end
               end else if (widx_ff == (WAw+1)'(MapWords - 1)) begin
                  status_ff <= STATUS_NO_SPACE;
                  state_ff  <= S_OUT;
               end else begin
                  widx_ff  <= widx_ff + (WAw+1)'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_MUL: begin
               prod_ff  <= 32'(group_ff) * 32'(per_group);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               number_ff <= prod_ff + bit_ff + (pool_ff ? 32'd0 : 32'd1);
               state_ff  <= S_OUT;
            end
            S_MOD: begin
               // restoring division, one quotient bit per cycle
               num_ff <= {num_ff[30:0], 1'b0};
               if (rem_sh >= 33'(per_group)) rem_ff <= 32'(rem_sh - 33'(per_group));
               else                          rem_ff <= rem_sh[31:0];
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) state_ff <= S_FREE_RD;
            end
            S_FREE_RD: begin
               // with a zero count the divider leaves the whole number in rem (x mod 0 == x)
               bit_ff   <= rem_ff;
               state_ff <= S_FREE_CHK;
            end
            S_FREE_CHK: begin
               if (in_map && ((rd_data_ff & bitmask) != '0)) begin
                  if (pool_ff) begin
                     if (bused_ff != '0) bused_ff <= bused_ff - CfgWidth'(1);
                  end else if (iused_ff != '0) iused_ff <= iused_ff - CfgWidth'(1);
               end else begin
                  status_ff <= STATUS_ALREADY_FREE;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // wait until the output register is free
               if (!rvalid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if ((state_ff == S_OUT) && (!rvalid_ff || rsp_tready)) begin
            rvalid_ff   <= 1'b1;
            rsp_data_ff <= {(pool_ff ? bused_ff : iused_ff), number_ff, status_ff};
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end
endmodule

// ----- src/gba_checker.sv -----
// port-level checker for the group bitmap allocator, bound to the top level
`include "group_bitmap_allocator_defines.svh"
module gba_checker
   import gba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   `GBA_ASSERT(a_status_code, clock, reset, !rsp_tvalid || rsp_tdata[1:0] != 2'd3, "bad status")
   `GBA_ASSERT(a_fail_zero, clock, reset, !rsp_tvalid || rsp_tdata[1:0] == STATUS_OK || rsp_tdata[33:2] == 32'd0, "number on failure")
   `GBA_ASSERT(a_one_busy, clock, reset, !(req_tready && rsp_tvalid && !rsp_tready && $past(req_tvalid && req_tready)), "accept while result pending")
   `GBA_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
endmodule

bind group_bitmap_allocator gba_checker u_gba_checker (.*);
